// File: hw/rtl/rls_two_parameter_estimator_core_defines.svh
// Assertion macros shared by the estimator RTL.
`ifndef RLS_TWO_PARAMETER_ESTIMATOR_CORE_DEFINES_SVH
`define RLS_TWO_PARAMETER_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define RLSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlse assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define RLSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlse assertion failed");

`endif

// File: hw/rtl/rlse_pkg.sv
// Package: types, constants and microprogram of the RLS estimator.
package rlse_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [30:0] LAM_LO        = 31'd536870912;
  localparam logic [30:0] LAM_HI        = 31'd1073741824;
  localparam logic [30:0] LAM_RESET     = 31'd1063004406;
  localparam logic [30:0] P0_RESET      = 31'd6553600;
  localparam int          CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FORGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_P0     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THA    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THB    = 2'd3;

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PC_RST  = 6'd0;
  localparam logic [PC_W-1:0] PC_REI  = 6'd7;
  localparam logic [PC_W-1:0] PC_UPD  = 6'd14;
  localparam logic [PC_W-1:0] PC_SKIP = 6'd63;
  localparam int NUM_SLOTS = 26;

  typedef enum logic [2:0] {
    OP_END, OP_LDK, OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_CHK
  } op_t;

  typedef enum logic [4:0] {
    S_P0, S_P1, S_P2, S_P3, S_TH0, S_TH1, S_F0, S_F1, S_Y, S_LAMQ,
    S_PP0, S_PP1, S_DEN, S_K0, S_K1, S_ERR, S_A, S_B, S_C, S_D,
    S_Q00, S_Q01, S_Q10, S_Q11, S_T0, S_T1
  } slot_t;

  typedef enum logic [3:0] {
    K_ZERO, K_P100, K_P0, K_THA, K_THB, K_Y, K_F0, K_F1, K_LAMQ
  } ksel_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_DIVW
  } ctrl_state_t;

  typedef struct packed {
    op_t   op;
    slot_t dst;
    slot_t ra;
    slot_t rb;
    ksel_t ks;
    logic  dlam;
  } instr_t;

  typedef struct packed {
    logic   exec;
    logic   accept;
    logic   emit;
    instr_t ins;
  } cmd_t;

  typedef struct packed {
    logic den_pos;
    logic div_done;
    logic out_busy;
  } status_t;

  function automatic instr_t mk(op_t op, slot_t dst, slot_t ra, slot_t rb, ksel_t ks,
                                logic dlam);
    instr_t i;
    i.op = op; i.dst = dst; i.ra = ra; i.rb = rb; i.ks = ks; i.dlam = dlam;
    return i;
  endfunction

  function automatic instr_t ldk(slot_t dst, ksel_t ks);
    return mk(OP_LDK, dst, S_T0, S_T0, ks, 1'b0);
  endfunction

  function automatic instr_t alu(op_t op, slot_t dst, slot_t ra, slot_t rb);
    return mk(op, dst, ra, rb, K_ZERO, 1'b0);
  endfunction

  // Microprogram: reset load, reinitialize, update.
  function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
    instr_t i;
    i = mk(OP_END, S_T0, S_T0, S_T0, K_ZERO, 1'b0);
    case (pc)
      6'd0:  i = ldk(S_P0, K_P100);
      6'd1:  i = ldk(S_P1, K_ZERO);
      6'd2:  i = ldk(S_P2, K_ZERO);
      6'd3:  i = ldk(S_P3, K_P100);
      6'd4:  i = ldk(S_TH0, K_ZERO);
      6'd5:  i = ldk(S_TH1, K_ZERO);
      6'd7:  i = ldk(S_P0, K_P0);
      6'd8:  i = ldk(S_P1, K_ZERO);
      6'd9:  i = ldk(S_P2, K_ZERO);
      6'd10: i = ldk(S_P3, K_P0);
      6'd11: i = ldk(S_TH0, K_THA);
      6'd12: i = ldk(S_TH1, K_THB);
      6'd14: i = ldk(S_Y, K_Y);
      6'd15: i = ldk(S_F0, K_F0);
      6'd16: i = ldk(S_F1, K_F1);
      6'd17: i = ldk(S_LAMQ, K_LAMQ);
      6'd18: i = alu(OP_MUL, S_T0, S_P0, S_F0);
      6'd19: i = alu(OP_MUL, S_T1, S_P1, S_F1);
      6'd20: i = alu(OP_ADD, S_PP0, S_T0, S_T1);
      6'd21: i = alu(OP_MUL, S_T0, S_P2, S_F0);
      6'd22: i = alu(OP_MUL, S_T1, S_P3, S_F1);
      6'd23: i = alu(OP_ADD, S_PP1, S_T0, S_T1);
      6'd24: i = alu(OP_MUL, S_T0, S_F0, S_PP0);
      6'd25: i = alu(OP_MUL, S_T1, S_F1, S_PP1);
      6'd26: i = alu(OP_ADD, S_T0, S_T0, S_T1);
      6'd27: i = alu(OP_ADD, S_DEN, S_LAMQ, S_T0);
      6'd28: i = alu(OP_CHK, S_T0, S_DEN, S_DEN);
      6'd29: i = alu(OP_DIV, S_K0, S_PP0, S_DEN);
      6'd30: i = alu(OP_DIV, S_K1, S_PP1, S_DEN);
      6'd31: i = alu(OP_MUL, S_T0, S_F0, S_TH0);
      6'd32: i = alu(OP_MUL, S_T1, S_F1, S_TH1);
      6'd33: i = alu(OP_ADD, S_T0, S_T0, S_T1);
      6'd34: i = alu(OP_SUB, S_ERR, S_Y, S_T0);
      6'd35: i = alu(OP_MUL, S_T0, S_K0, S_ERR);
      6'd36: i = alu(OP_ADD, S_TH0, S_TH0, S_T0);
      6'd37: i = alu(OP_MUL, S_T0, S_K1, S_ERR);
      6'd38: i = alu(OP_ADD, S_TH1, S_TH1, S_T0);
      6'd39: i = alu(OP_MUL, S_A, S_K0, S_F0);
      6'd40: i = alu(OP_MUL, S_B, S_K0, S_F1);
      6'd41: i = alu(OP_MUL, S_C, S_K1, S_F0);
      6'd42: i = alu(OP_MUL, S_D, S_K1, S_F1);
      6'd43: i = alu(OP_MUL, S_T0, S_A, S_P0);
      6'd44: i = alu(OP_MUL, S_T1, S_B, S_P2);
      6'd45: i = alu(OP_ADD, S_T0, S_T0, S_T1);
      6'd46: i = alu(OP_SUB, S_Q00, S_P0, S_T0);
      6'd47: i = alu(OP_MUL, S_T0, S_A, S_P1);
      6'd48: i = alu(OP_MUL, S_T1, S_B, S_P3);
      6'd49: i = alu(OP_ADD, S_T0, S_T0, S_T1);
      6'd50: i = alu(OP_SUB, S_Q01, S_P1, S_T0);
      6'd51: i = alu(OP_MUL, S_T0, S_C, S_P0);
      6'd52: i = alu(OP_MUL, S_T1, S_D, S_P2);
      6'd53: i = alu(OP_ADD, S_T0, S_T0, S_T1);
      6'd54: i = alu(OP_SUB, S_Q10, S_P2, S_T0);
      6'd55: i = alu(OP_MUL, S_T0, S_C, S_P1);
      6'd56: i = alu(OP_MUL, S_T1, S_D, S_P3);
      6'd57: i = alu(OP_ADD, S_T0, S_T0, S_T1);
      6'd58: i = alu(OP_SUB, S_Q11, S_P3, S_T0);
      6'd59: i = mk(OP_DIV, S_P0, S_Q00, S_Q00, K_ZERO, 1'b1);
      6'd60: i = mk(OP_DIV, S_P1, S_Q01, S_Q01, K_ZERO, 1'b1);
      6'd61: i = mk(OP_DIV, S_P2, S_Q10, S_Q10, K_ZERO, 1'b1);
      6'd62: i = mk(OP_DIV, S_P3, S_Q11, S_Q11, K_ZERO, 1'b1);
      default: i = mk(OP_END, S_T0, S_T0, S_T0, K_ZERO, 1'b0);
    endcase
    return i;
  endfunction

endpackage

// File: hw/rtl/rlse_in_if.sv
// Input channel interface: update or reinitialize transactions.
interface rlse_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] measured;
  logic signed [31:0] regressor_a;
  logic signed [31:0] regressor_b;

  modport source (output valid, req_type, measured, regressor_a, regressor_b,
                  input ready);
  modport sink   (input valid, req_type, measured, regressor_a, regressor_b,
                  output ready);
endinterface

// File: hw/rtl/rlse_out_if.sv
// Result channel interface: estimates, error and flags.
interface rlse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate_a;
  logic signed [31:0] estimate_b;
  logic signed [31:0] prediction_error;
  logic               skipped;
  logic               saturated;

  modport source (output valid, estimate_a, estimate_b, prediction_error, skipped,
                  saturated, input ready);
  modport sink   (input valid, estimate_a, estimate_b, prediction_error, skipped,
                  saturated, output ready);
endinterface

// File: hw/rtl/rls_two_parameter_estimator_core.sv
// Top level of the two-parameter RLS estimator with forgetting factor.
//
// Input channel in_ch carries one transaction per request: req_type 0 runs an
// estimator update with measured and the two regressor values, req_type 1
// reloads theta and P = p0 * I from the configuration registers. Every
// transaction returns exactly one result on out_ch: both estimates, the
// prediction error and the skipped / saturated flags.
// Each microprogram step reads its operands from the slot memory (FETCH),
// then executes through the shared multiplier or adder (EXEC). A division runs on
// the serial divider at one quotient bit per cycle, DATA_WIDTH + 30 bits.
// An update ends early when the denominator test skips.
// The block works one transaction at a time; in_ch.ready is high while idle.
// After reset the sequencer loads P = 100.0 * I and theta = 0 before it
// raises ready. The result sits in an output register, so a stalled
// receiver does not hold up the next transaction until its result is due;
// then the sequencer holds until the old result is taken.
// Configuration writes on cfg_* are taken any cycle, meant only while idle.
module rls_two_parameter_estimator_core
  import rlse_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rlse_in_if.sink              in_ch,
  rlse_out_if.source           out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wr_data
);

  cmd_t    cmd;
  status_t st;

  // Sequencer; each request picks its program entry on acceptance.
  rlse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_req_type(in_ch.req_type),
    .st         (st),
    .in_ready   (in_ch.ready),
    .cmd        (cmd)
  );

  // Datapath: capture the transaction, run the arithmetic, hold the result.
  rlse_dpath #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wr_data         (cfg_wr_data),
    .in_measured         (in_ch.measured),
    .in_regressor_a      (in_ch.regressor_a),
    .in_regressor_b      (in_ch.regressor_b),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_estimate_a      (out_ch.estimate_a),
    .out_estimate_b      (out_ch.estimate_b),
    .out_prediction_error(out_ch.prediction_error),
    .out_skipped         (out_ch.skipped),
    .out_saturated       (out_ch.saturated)
  );

endmodule

// File: hw/rtl/rlse_div.sv
// Serial restoring divider: (|num| << shift) / den, signed and saturated.
module rlse_div
  import rlse_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         use30,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic [((DATA_WIDTH > 31) ? DATA_WIDTH : 31)-1:0] den,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quot,
  output logic                         clip
);

  localparam int DW  = DATA_WIDTH;
  localparam int DVW = (DW > 31) ? DW : 31;
  localparam int NW  = DW + 30;
  localparam int CW  = $clog2(NW + 1);

  logic          busy_r, fin_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] n_r, q_r;
  logic [DVW-1:0] r_r, d_r;
  logic          neg_r;

  logic [DW-1:0]  mag_in;
  logic [NW-1:0]  n_init, lim;
  logic [DVW:0]   rs, rdiff;
  logic           ge;

  assign mag_in = num[DW-1] ? DW'(-num) : DW'(num);
  assign n_init = use30 ? (NW'(mag_in) << 30) : (NW'(mag_in) << FRAC_BITS);
  assign rs     = {r_r, n_r[NW-1]};
  assign ge     = rs >= {1'b0, d_r};
  assign rdiff  = rs - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n_init;
      q_r   <= '0;
      r_r   <= '0;
      d_r   <= den;
      neg_r <= num[DW-1];
    end else if (busy_r) begin
      n_r <= {n_r[NW-2:0], 1'b0};
      q_r <= {q_r[NW-2:0], ge};
      r_r <= ge ? rdiff[DVW-1:0] : rs[DVW-1:0];
    end
  end

  // Saturate the magnitude to the signed range.
  assign lim  = neg_r ? (NW'(1) << (DW - 1)) : ((NW'(1) << (DW - 1)) - NW'(1));
  assign clip = q_r > lim;
  assign done = fin_r;
  always_comb begin
    if (clip) begin
      quot = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      quot = neg_r ? $signed(-q_r[DW-1:0]) : $signed(q_r[DW-1:0]);
    end
  end

endmodule

// File: hw/rtl/rlse_ctrl.sv
// Sequencer: steps the microprogram and drives datapath commands.
`include "rls_two_parameter_estimator_core_defines.svh"
module rlse_ctrl
  import rlse_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_req_type,
  input  status_t st,
  output logic    in_ready,
  output cmd_t    cmd
);

  ctrl_state_t     state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            emit_r, emit_nxt;
  instr_t          ins;

  assign ins = prog_rom(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FETCH;
      pc_r    <= PC_RST;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FETCH;
          // Program entry chosen on acceptance.
          pc_nxt    = in_req_type ? PC_REI : PC_UPD;
          emit_nxt  = 1'b1;
        end
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC: begin
        unique case (ins.op)
          OP_DIV: state_nxt = ST_DIVW;
          OP_CHK: begin
            state_nxt = ST_FETCH;
            pc_nxt    = st.den_pos ? pc_r + PC_W'(1) : PC_SKIP;
          end
          OP_END: begin
            if (!(emit_r && st.out_busy)) begin
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_FETCH;
            pc_nxt    = pc_r + PC_W'(1);
          end
        endcase
      end
      ST_DIVW: begin
        if (st.div_done) begin
          state_nxt = ST_FETCH;
          pc_nxt    = pc_r + PC_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd.exec   = 1'b0;
    cmd.accept = 1'b0;
    cmd.emit   = emit_r;
    cmd.ins    = ins;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EXEC:  cmd.exec = 1'b1;
      ST_FETCH: cmd.exec = 1'b0;
      ST_DIVW:  cmd.exec = 1'b0;
      default:  cmd.exec = 1'b0;
    endcase
  end

  `RLSE_ASSERT_NXT(a_accept_fetch, state_r == ST_IDLE && in_valid,
                   state_r == ST_FETCH && emit_r)
  `RLSE_ASSERT_IMP(a_divw_op, state_r == ST_DIVW, ins.op == OP_DIV)
  `RLSE_ASSERT_IMP(a_done_in_wait, st.div_done, state_r == ST_DIVW)

endmodule

// File: hw/rtl/rlse_dpath.sv
// Datapath: slot memory, shared multiplier, adder, config and result registers.
module rlse_dpath
  import rlse_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              st,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wr_data,
  input  logic signed [31:0]   in_measured,
  input  logic signed [31:0]   in_regressor_a,
  input  logic signed [31:0]   in_regressor_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_estimate_a,
  output logic signed [31:0]   out_estimate_b,
  output logic signed [31:0]   out_prediction_error,
  output logic                 out_skipped,
  output logic                 out_saturated
);

  localparam int DW  = DATA_WIDTH;
  localparam int DVW = (DW > 31) ? DW : 31;
  localparam int PW  = 2 * DW;
  localparam int XW  = DW + 40;
  localparam logic signed [XW-1:0] XMAX = $signed({{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [XW-1:0] XMIN = -XMAX - XW'(1);
  localparam logic signed [XW-1:0] YMAX = $signed({{(XW-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [XW-1:0] YMIN = -YMAX - XW'(1);

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [XW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > XMAX)      r = XMAX[DW-1:0];
    else if (v < XMIN) r = XMIN[DW-1:0];
    else               r = v[DW-1:0];
    return r;
  endfunction

  function automatic logic clip_dw(input logic signed [XW-1:0] v);
    return (v > XMAX) || (v < XMIN);
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [DW-1:0] d);
    logic signed [XW-1:0] v;
    logic signed [31:0]   r;
    v = XW'(d);
    if (v > YMAX)      r = YMAX[31:0];
    else if (v < YMIN) r = YMIN[31:0];
    else               r = v[31:0];
    return r;
  endfunction

  function automatic logic clip_32(input logic signed [DW-1:0] d);
    logic signed [XW-1:0] v;
    v = XW'(d);
    return (v > YMAX) || (v < YMIN);
  endfunction

  // Configuration registers.
  logic [30:0]        lam_r, p0_r;
  logic signed [31:0] tha_r, thb_r;
  logic [30:0]        lam_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r <= LAM_RESET;
      p0_r  <= P0_RESET;
      tha_r <= '0;
      thb_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FORGET: lam_r <= cfg_wr_data[30:0];
        CFG_P0:     p0_r  <= cfg_wr_data[30:0];
        CFG_THA:    tha_r <= $signed(cfg_wr_data);
        CFG_THB:    thb_r <= $signed(cfg_wr_data);
        default:    lam_r <= lam_r;
      endcase
    end
  end

  assign lam_c = (lam_r < LAM_LO) ? LAM_LO : ((lam_r > LAM_HI) ? LAM_HI : lam_r);

  // Captured transaction; req_type itself only selects the program.
  logic signed [31:0] y_r, f0_r, f1_r;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      y_r  <= in_measured;
      f0_r <= in_regressor_a;
      f1_r <= in_regressor_b;
    end
  end

  // Slot memory with registered read ports.
  logic signed [DW-1:0] mem [NUM_SLOTS];
  logic signed [DW-1:0] rda_r, rdb_r;
  logic                 wr_en, wr_clip;
  logic signed [DW-1:0] wr_data;

  always_ff @(posedge clk) begin
    rda_r <= mem[cmd.ins.ra];
    rdb_r <= mem[cmd.ins.rb];
    if (wr_en) begin
      mem[cmd.ins.dst] <= wr_data;
    end
  end

  // Shared multiplier: sign-magnitude product, floor rounding, saturation.
  logic [DW-1:0]        ma, mb;
  logic [PW-1:0]        prod;
  logic [PW:0]          qr, mlim;
  logic                 mneg, mclip;
  logic signed [DW-1:0] mres;

  assign ma   = rda_r[DW-1] ? DW'(-rda_r) : DW'(rda_r);
  assign mb   = rdb_r[DW-1] ? DW'(-rdb_r) : DW'(rdb_r);
  assign prod = PW'(ma) * PW'(mb);
  assign mneg = rda_r[DW-1] ^ rdb_r[DW-1];
  assign qr   = {1'b0, prod >> FRAC_BITS}
              + (PW+1)'(mneg && (prod[FRAC_BITS-1:0] != '0));
  assign mlim = mneg ? ((PW+1)'(1) << (DW - 1)) : (((PW+1)'(1) << (DW - 1)) - (PW+1)'(1));
  assign mclip = qr > mlim;
  always_comb begin
    if (mclip) mres = mneg ? XMIN[DW-1:0] : XMAX[DW-1:0];
    else       mres = mneg ? $signed(-qr[DW-1:0]) : $signed(qr[DW-1:0]);
  end

  // Divider.
  logic                 div_done, div_clip;
  logic signed [DW-1:0] div_q;
  logic [DVW-1:0]       div_den;

  assign div_den = cmd.ins.dlam ? DVW'(lam_c) : DVW'($unsigned(rdb_r));

  rlse_div #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.exec && cmd.ins.op == OP_DIV),
    .use30(cmd.ins.dlam),
    .num  (rda_r),
    .den  (div_den),
    .done (div_done),
    .quot (div_q),
    .clip (div_clip)
  );

  // Write-back selection.
  logic signed [XW-1:0] ldx, sumx;
  always_comb begin
    case (cmd.ins.ks)
      K_P100:  ldx = XW'(100) <<< FRAC_BITS;
      K_P0:    ldx = $signed(XW'(p0_r));
      K_THA:   ldx = XW'(tha_r);
      K_THB:   ldx = XW'(thb_r);
      K_Y:     ldx = XW'(y_r);
      K_F0:    ldx = XW'(f0_r);
      K_F1:    ldx = XW'(f1_r);
      K_LAMQ:  ldx = $signed(XW'(lam_c >> (30 - FRAC_BITS)));
      default: ldx = '0;
    endcase
    sumx = (cmd.ins.op == OP_SUB) ? (XW'(rda_r) - XW'(rdb_r)) : (XW'(rda_r) + XW'(rdb_r));
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    wr_clip = 1'b0;
    if (div_done) begin
      wr_en   = 1'b1;
      wr_data = div_q;
      wr_clip = div_clip;
    end else if (cmd.exec) begin
      case (cmd.ins.op)
        OP_LDK: begin
          wr_en = 1'b1; wr_data = sat_dw(ldx); wr_clip = clip_dw(ldx);
        end
        OP_MUL: begin
          wr_en = 1'b1; wr_data = mres; wr_clip = mclip;
        end
        OP_ADD, OP_SUB: begin
          wr_en = 1'b1; wr_data = sat_dw(sumx); wr_clip = clip_dw(sumx);
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // Per-transaction state: theta and error copies, flags, result register.
  logic signed [DW-1:0] th0_r, th1_r, err_r;
  logic                 skip_r, clip_r, out_valid_r, capture;
  logic signed [31:0]   est_a_r, est_b_r, perr_r;
  logic                 oskip_r, osat_r;

  assign capture = cmd.exec && cmd.ins.op == OP_END && cmd.emit && !st.out_busy;

  always_ff @(posedge clk) begin
    if (wr_en && cmd.ins.dst == S_TH0) th0_r <= wr_data;
    if (wr_en && cmd.ins.dst == S_TH1) th1_r <= wr_data;
    if (cmd.accept) begin
      err_r <= '0;
    end else if (wr_en && cmd.ins.dst == S_ERR) begin
      err_r <= wr_data;
    end
    if (capture) begin
      est_a_r <= sat_32(th0_r);
      est_b_r <= sat_32(th1_r);
      perr_r  <= sat_32(err_r);
      oskip_r <= skip_r;
      osat_r  <= clip_r | clip_32(th0_r) | clip_32(th1_r) | clip_32(err_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r      <= 1'b0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        skip_r <= 1'b0;
        clip_r <= 1'b0;
      end else begin
        if (cmd.exec && cmd.ins.op == OP_CHK && !st.den_pos) skip_r <= 1'b1;
        if (wr_en && wr_clip) clip_r <= 1'b1;
      end
      out_valid_r <= capture | (out_valid_r & ~out_ready);
    end
  end

  assign st = '{den_pos:  !rda_r[DW-1] && (rda_r != '0),
                div_done: div_done,
                out_busy: out_valid_r & ~out_ready};

  assign out_valid            = out_valid_r;
  assign out_estimate_a       = est_a_r;
  assign out_estimate_b       = est_b_r;
  assign out_prediction_error = perr_r;
  assign out_skipped          = oskip_r;
  assign out_saturated        = osat_r;

endmodule
